// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the recorder block.
// Each use names a label and expressions; clk and rst_n are taken from the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/pkuvr_pkg.sv =====
package pkuvr_pkg;

    localparam int KEYS  = 512;
    localparam int SLOTS = 20;

    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 64;
    localparam int SLOT_W   = 6;
    localparam int KEY_AW   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);

    localparam logic [VALUE_W-1:0] RESERVED_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef logic [SLOTS-1:0][VALUE_W-1:0] row_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic                      status;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] stored_value;
    } out_word_t;

    typedef struct packed {
        logic             hit;
        logic             full;
        logic             reserved;
        logic [CNT_W-1:0] n;
    } check_t;

endpackage

// ===== hw/rtl/pkuvr_ram.sv =====
module pkuvr_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 512,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pkuvr_check.sv =====
module pkuvr_check (
    input  pkuvr_pkg::row_t                    row,
    input  logic [pkuvr_pkg::CNT_W-1:0]        count,
    input  logic signed [pkuvr_pkg::VALUE_W-1:0] value,
    output pkuvr_pkg::check_t                  chk,
    output pkuvr_pkg::row_t                    row_new
);
    import pkuvr_pkg::*;

    logic [CNT_W-1:0] n;
    logic             hit;

    always_comb
    begin
        n = (count > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : count;
        hit = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if ((CNT_W'(i) < n) && (row[i] == value))
            begin
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            row_new[i] = (CNT_W'(i) == n) ? value : row[i];
        end
    end

    assign chk.hit      = hit;
    assign chk.full     = (n >= CNT_W'(SLOTS));
    assign chk.reserved = (value == RESERVED_VALUE);
    assign chk.n        = n;

endmodule

// ===== hw/rtl/per_key_unique_value_recorder_unit.sv =====
// Per-key unique value recorder.
// Input: a word (key, value) is taken at a clock edge with start high and busy low.
// Output: a result word is on result for one cycle, marked by strobe. The receiver
// cannot stall; every result is taken in the cycle it appears.
// A key at or above KEYS, a value already held for the key, or the reserved
// value with a free slot gives no result. A new value goes into the key's next
// slot; a full key reports overflow (status 1, slot 0, value 0).
// Timing: the key's slot row and fill count are read from block RAM in the
// accept cycle, compared and written back in the next. The result is registered
// at the end of the check and appears in the cycle after it. Busy is high while
// an accepted in-range key is checked, so a new word is taken only once that
// check is done; an out-of-range key frees the input at once. The RAM read ahead
// of the read-modify-write of the row is what holds the input for the check.
// Reset: after rst_n is released the fill counts are cleared one key a cycle,
// with busy high. Slot contents are never cleared.
`include "assert_macros.svh"

module per_key_unique_value_recorder_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pkuvr_pkg::in_word_t  item,
    output logic                 strobe,
    output pkuvr_pkg::out_word_t result
);
    import pkuvr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } state_t;

    state_t              state_reg;
    logic [KEY_AW-1:0]   clr_idx_reg;
    logic                strobe_reg;
    out_word_t           result_reg;
    logic [KEY_AW-1:0]   key_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic                accept;
    logic                key_ok;
    logic                clearing;
    row_t                row_rd;
    row_t                row_new;
    logic [CNT_W-1:0]    cnt_rd;
    check_t              chk;
    logic                store_en;
    logic                fill_we;
    logic [KEY_AW-1:0]   fill_waddr;
    logic [CNT_W-1:0]    fill_wdata;

    assign busy     = (state_reg != ST_IDLE);
    assign key_ok   = (32'(item.key) < KEYS);
    assign accept   = start && !busy && key_ok;
    assign clearing = (state_reg == ST_CLEAR);

    assign store_en   = (state_reg == ST_CHECK) && !chk.hit && !chk.full && !chk.reserved;
    assign fill_we    = clearing || store_en;
    assign fill_waddr = clearing ? clr_idx_reg : key_reg;
    assign fill_wdata = clearing ? '0 : (chk.n + CNT_W'(1));

    pkuvr_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (KEYS)
    ) u_row_ram (
        .clk   (clk),
        .we    (store_en),
        .waddr (key_reg),
        .wdata (row_new),
        .re    (accept),
        .raddr (item.key[KEY_AW-1:0]),
        .rdata (row_rd)
    );

    pkuvr_ram #(
        .WIDTH (CNT_W),
        .DEPTH (KEYS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (accept),
        .raddr (item.key[KEY_AW-1:0]),
        .rdata (cnt_rd)
    );

    pkuvr_check u_check (
        .row     (row_rd),
        .count   (cnt_rd),
        .value   (value_reg),
        .chk     (chk),
        .row_new (row_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            strobe_reg  <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    strobe_reg  <= 1'b0;
                    clr_idx_reg <= clr_idx_reg + KEY_AW'(1);
                    if (clr_idx_reg == KEY_AW'(KEYS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    strobe_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= ST_IDLE;
                    if (!chk.hit && chk.full)
                    begin
                        strobe_reg              <= 1'b1;
                        result_reg.status       <= 1'b1;
                        result_reg.slot         <= '0;
                        result_reg.stored_value <= '0;
                    end
                    else if (!chk.hit && !chk.reserved)
                    begin
                        strobe_reg              <= 1'b1;
                        result_reg.status       <= 1'b0;
                        result_reg.slot         <= SLOT_W'(chk.n);
                        result_reg.stored_value <= value_reg;
                    end
                    else
                    begin
                        strobe_reg <= 1'b0;
                    end
                end
                default:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= ST_IDLE;
                end
            endcase
        end
    end

    // word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= item.key[KEY_AW-1:0];
            value_reg <= item.value;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `ASSERT_IMPLIES(a_strobe_after_check, strobe_reg, $past(state_reg) == ST_CHECK)
    `ASSERT_NEXT(a_check_one_cycle, state_reg == ST_CHECK, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_slot_in_range, strobe_reg && !result_reg.status, 32'(result_reg.slot) < SLOTS)
    `ASSERT_IMPLIES(a_overflow_zero, strobe_reg && result_reg.status, (result_reg.slot == '0) && (result_reg.stored_value == '0))
    `ASSERT_IMPLIES(a_no_store_on_clear, clearing, !store_en)

endmodule

// ===== verif/tb_per_key_unique_value_recorder_unit.sv =====
module tb_per_key_unique_value_recorder_unit;

    import pkuvr_pkg::*;

    localparam int RANDOM_WORDS = 1450;
    localparam int HOT_KEYS     = 8;
    localparam int POOL_SIZE    = 28;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_word_t  item = '0;
    logic      strobe;
    out_word_t result;

    per_key_unique_value_recorder_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always #5 clk = ~clk;

    // predictor state
    logic signed [VALUE_W-1:0] held_values [KEYS][SLOTS];
    int unsigned               fill_counts [KEYS];

    in_word_t  observations_q[$];
    out_word_t recorded_q[$];
    int        mismatches = 0;

    bit          sending = 1'b0;
    bit          word_taken = 1'b0;
    bit          burst_mode = 1'b0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    in_word_t    cur_word = '0;

    out_word_t predicted;
    out_word_t want;

    logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];
    logic [KEY_W-1:0]          hot_keys [HOT_KEYS];

    function automatic bit record_value(input in_word_t w, output out_word_t rec);
        int unsigned k;
        int unsigned n;
        k = 32'(w.key);
        rec = '0;
        if (k >= KEYS)
            return 1'b0;
        n = fill_counts[k];
        for (int i = 0; i < n; i++)
        begin
            if (held_values[k][i] == w.value)
                return 1'b0;
        end
        if (n >= SLOTS)
        begin
            rec.status = 1'b1;
            return 1'b1;
        end
        if (w.value == RESERVED_VALUE)
            return 1'b0;
        held_values[k][n] = w.value;
        fill_counts[k] = n + 1;
        rec.status = 1'b0;
        rec.slot = SLOT_W'(n);
        rec.stored_value = w.value;
        return 1'b1;
    endfunction

    task automatic queue_observation(input logic [KEY_W-1:0] k,
                                     input logic signed [VALUE_W-1:0] v);
        in_word_t w;
        w.key = k;
        w.value = v;
        observations_q.push_back(w);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sending && word_taken)
            begin
                sending = 1'b0;
                if (burst_left == 0)
                begin
                    burst_mode = ($urandom_range(0, 3) == 0);
                    burst_left = $urandom_range(10, 60);
                end
                else
                    burst_left--;
                gap_left = burst_mode ? 0 : $urandom_range(0, 11);
            end
            word_taken = 1'b0;
            if (!sending)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (observations_q.size() != 0)
                begin
                    cur_word = observations_q.pop_front();
                    sending = 1'b1;
                end
            end
            start <= sending;
            item <= cur_word;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                if (recorded_q.size() == 0)
                begin
                    $error("unexpected word: status %0d slot %0d stored_value %0d",
                           result.status, result.slot, result.stored_value);
                    mismatches++;
                end
                else
                begin
                    want = recorded_q.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, result.status);
                        mismatches++;
                    end
                    if (result.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, result.slot);
                        mismatches++;
                    end
                    if (result.stored_value !== want.stored_value)
                    begin
                        $error("stored_value: expected %0d, actual %0d",
                               want.stored_value, result.stored_value);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (record_value(item, predicted))
                    recorded_q.push_back(predicted);
                word_taken = 1'b1;
            end
        end
    end

    initial
    begin
        int counted;
        int pick;
        logic [KEY_W-1:0] k;
        logic signed [VALUE_W-1:0] v;

        // directed: extremes, repeats, reserved value, range edge, full key
        queue_observation(0, 0);
        queue_observation(0, 0);
        queue_observation(0, {1'b1, 63'd0});
        queue_observation(0, 64'sh7FFF_FFFF_FFFF_FFFE);
        queue_observation(0, -64'sd1);
        queue_observation(0, RESERVED_VALUE);
        queue_observation(KEY_W'(KEYS - 1), 5);
        queue_observation(KEY_W'(KEYS), 1);
        queue_observation(16'hFFFF, -64'sd1);
        for (int i = 1; i <= SLOTS - 4; i++)
            queue_observation(0, VALUE_W'(i));
        queue_observation(0, 100);
        queue_observation(0, RESERVED_VALUE);
        queue_observation(0, {1'b1, 63'd0});

        value_pool[0] = {1'b1, 63'd0};
        value_pool[1] = 64'sh7FFF_FFFF_FFFF_FFFE;
        value_pool[2] = 0;
        value_pool[3] = -64'sd1;
        value_pool[4] = 1;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = {$urandom(), $urandom()};
        hot_keys[0] = KEY_W'(KEYS - 1);
        for (int i = 1; i < HOT_KEYS; i++)
            hot_keys[i] = KEY_W'($urandom_range(0, KEYS - 1));

        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                k = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            else if (pick < 72)
            begin
                k = KEY_W'($urandom_range(0, KEYS - 1));
                v = {$urandom(), $urandom()};
            end
            else if (pick < 82)
            begin
                k = KEY_W'($urandom_range(0, KEYS - 1));
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            else if (pick < 92)
            begin
                k = KEY_W'($urandom_range(KEYS, 16'hFFFF));
                v = {$urandom(), $urandom()};
            end
            else
            begin
                k = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
                v = RESERVED_VALUE;
            end
            queue_observation(k, v);
            counted++;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (observations_q.size() != 0 || sending)
            @(posedge clk);
        while (recorded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);

        if (mismatches == 0)
            $display("** per_key_unique_value_recorder_unit: PASSED **");
        else
            $display("** per_key_unique_value_recorder_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** per_key_unique_value_recorder_unit: FAILED **");
        $finish;
    end

endmodule
